[src/ardt_pkg.sv]
// ----------------------------------------------------------------------------
// ardt_pkg
// Shared constants and types of the ambient rejecting tape detector.
// ----------------------------------------------------------------------------
package ardt_pkg;

    localparam int SENSOR_COUNT    = 7;
    localparam int SAMPLES_LOG2    = 1;
    localparam int CONFIRM_WINDOWS = 3;
    localparam int SAMPLE_BITS     = 10;

    localparam int THRESH_W   = 10;
    localparam int SUM_W      = SAMPLE_BITS + SAMPLES_LOG2;
    localparam int CMP_W      = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
    localparam int PHASE_LEN  = 1 << SAMPLES_LOG2;
    localparam int SIDX_W     = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
    localparam int WIN_W      = (CONFIRM_WINDOWS > 1) ? $clog2(CONFIRM_WINDOWS) : 1;
    localparam int AGREE_W    = $clog2(CONFIRM_WINDOWS + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [THRESH_W-1:0] ON_THRESH_RESET  = THRESH_W'(8'h22);
    localparam logic [THRESH_W-1:0] OFF_THRESH_RESET = THRESH_W'(8'h35);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_THRESH  = 2'd0,
        REG_OFF_THRESH = 2'd1
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // per-item control broadcast to every lane
    typedef struct packed {
        logic advance;
        logic phase;
        logic phase_end;
        logic window_done;
    } lane_ctrl_t;

endpackage

[src/ardt_if.sv]
// ----------------------------------------------------------------------------
// ardt interfaces
// Valid/ready channels for sample sets, results and register writes.
// ----------------------------------------------------------------------------
interface ardt_sample_if
    import ardt_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, input ready);
    modport sink (input valid, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, output ready);
endinterface

interface ardt_result_if
    import ardt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    emitter_drive;
    logic [SENSOR_COUNT-1:0] tape_flags;
    logic                    flags_updated;
    logic                    any_on_tape;

    modport source (output valid, emitter_drive, tape_flags, flags_updated,
                    any_on_tape, input ready);
    modport sink (input valid, emitter_drive, tape_flags, flags_updated,
                  any_on_tape, output ready);
endinterface

interface ardt_cfg_if
    import ardt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THRESH_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/ardt_lane.sv]
// ----------------------------------------------------------------------------
// ardt_lane
// One sensor: dark/lit accumulation, ambient subtraction, hysteresis
// threshold and confirmation count.
// ----------------------------------------------------------------------------
module ardt_lane
    import ardt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctrl_t          ctrl,
    input  logic [THRESH_W-1:0] on_thr,
    input  logic [THRESH_W-1:0] off_thr,
    input  sample_t             sample,
    output logic                flag_next
);

    logic [SUM_W-1:0]   dark_reg, dark_next;
    logic [SUM_W-1:0]   lit_reg, lit_next;
    logic               hyst_reg, hyst_next;
    logic [AGREE_W-1:0] agree_reg, agree_next;
    logic               flag_reg;

    logic [SUM_W-1:0]    dark_sum;
    logic [SUM_W-1:0]    lit_sum;
    logic [SUM_W-1:0]    lit_avg;
    logic [SUM_W-1:0]    diff;
    logic [THRESH_W-1:0] thr;
    logic                tape;
    logic [AGREE_W-1:0]  agree_inc;

    always_comb
    begin
        dark_sum  = dark_reg + SUM_W'(sample);
        lit_sum   = lit_reg + SUM_W'(sample);
        lit_avg   = lit_sum >> SAMPLES_LOG2;
        diff      = lit_avg - dark_reg;
        thr       = hyst_reg ? off_thr : on_thr;
        // negative difference reads as off tape
        tape      = (lit_avg >= dark_reg) && (CMP_W'(diff) <= CMP_W'(thr));
        agree_inc = agree_reg + AGREE_W'(tape);

        dark_next  = dark_reg;
        lit_next   = lit_reg;
        hyst_next  = hyst_reg;
        agree_next = agree_reg;
        flag_next  = flag_reg;

        if (ctrl.advance)
        begin
            if (!ctrl.phase)
            begin
                dark_next = ctrl.phase_end ? (dark_sum >> SAMPLES_LOG2) : dark_sum;
            end
            else if (!ctrl.phase_end)
            begin
                lit_next = lit_sum;
            end
            else
            begin
                dark_next = '0;
                lit_next  = '0;
                hyst_next = tape;
                if (ctrl.window_done)
                begin
                    flag_next  = (agree_inc >= AGREE_W'(CONFIRM_WINDOWS));
                    agree_next = '0;
                end
                else
                begin
                    agree_next = agree_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg  <= '0;
            lit_reg   <= '0;
            hyst_reg  <= 1'b0;
            agree_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            dark_reg  <= dark_next;
            lit_reg   <= lit_next;
            hyst_reg  <= hyst_next;
            agree_reg <= agree_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

[src/ambient_rejecting_tape_detector.sv]
// ----------------------------------------------------------------------------
// ambient_rejecting_tape_detector
// Modulated reflectance tape detector: one sample set per word, per-sensor
// ambient rejection, hysteresis and multi-window confirmation.
// ----------------------------------------------------------------------------
// the accepted word is captured in the input register, and the lane update writes
// the result register when the output can advance (no result held, or it is taken)
// throughput: one word per cycle unless result.ready is low while a result is valid
// reset: thresholds return to 0x22 / 0x35, sums, counts and flags clear,
// emitter phase starts off
module ambient_rejecting_tape_detector
    import ardt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ardt_sample_if.sink   samples,
    ardt_result_if.source result,
    ardt_cfg_if.sink      cfg
);

    logic [THRESH_W-1:0] on_thr_reg, off_thr_reg;

    logic    in_valid_reg;
    sample_t in_samp_reg [SENSOR_COUNT];
    sample_t in_samp     [SENSOR_COUNT];

    logic              phase_reg, phase_next;
    logic [SIDX_W-1:0] sidx_reg, sidx_next;
    logic [WIN_W-1:0]  win_reg, win_next;

    logic                    out_valid_reg;
    logic                    out_emit_reg;
    logic [SENSOR_COUNT-1:0] out_flags_reg;
    logic                    out_upd_reg;
    logic                    out_any_reg;

    logic                    out_adv;
    lane_ctrl_t              ctrl;
    logic [SENSOR_COUNT-1:0] flags_next;

    assign in_samp[0] = samples.sample_0;
    assign in_samp[1] = samples.sample_1;
    assign in_samp[2] = samples.sample_2;
    assign in_samp[3] = samples.sample_3;
    assign in_samp[4] = samples.sample_4;
    assign in_samp[5] = samples.sample_5;
    assign in_samp[6] = samples.sample_6;

    assign out_adv       = !out_valid_reg || result.ready;
    assign samples.ready = !in_valid_reg || out_adv;
    assign cfg.ready     = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_thr_reg  <= ON_THRESH_RESET;
            off_thr_reg <= OFF_THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ON_THRESH:  on_thr_reg  <= cfg.data;
                REG_OFF_THRESH: off_thr_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_samp_reg <= in_samp;
        end
    end

    // phase sequencing
    always_comb
    begin
        ctrl.advance     = in_valid_reg && out_adv;
        ctrl.phase       = phase_reg;
        ctrl.phase_end   = (sidx_reg == SIDX_W'(PHASE_LEN - 1));
        ctrl.window_done = phase_reg && ctrl.phase_end
                           && (win_reg == WIN_W'(CONFIRM_WINDOWS - 1));

        phase_next = phase_reg;
        sidx_next  = sidx_reg;
        win_next   = win_reg;
        if (ctrl.advance)
        begin
            sidx_next = ctrl.phase_end ? '0 : sidx_reg + 1'b1;
            if (ctrl.phase_end)
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    win_next = ctrl.window_done ? '0 : win_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            sidx_reg  <= '0;
            win_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sidx_reg  <= sidx_next;
            win_reg   <= win_next;
        end
    end

    for (genvar s = 0; s < SENSOR_COUNT; s++)
    begin : g_lane
        ardt_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .on_thr    (on_thr_reg),
            .off_thr   (off_thr_reg),
            .sample    (in_samp_reg[s]),
            .flag_next (flags_next[s])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            out_emit_reg  <= phase_next;
            out_flags_reg <= flags_next;
            out_upd_reg   <= ctrl.window_done;
            out_any_reg   <= |flags_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.emitter_drive = out_emit_reg;
    assign result.tape_flags    = out_flags_reg;
    assign result.flags_updated = out_upd_reg;
    assign result.any_on_tape   = out_any_reg;

endmodule
